@@ rtl/core/cea_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cea_pkg
// Shared types, constants and the CORDIC step for the cube face to
// equirectangular address generator.
// ----------------------------------------------------------------------------
package cea_pkg;

    localparam int FACE_SIZE_DEF = 512;
    localparam int CORDIC_ITERS  = 24;
    localparam int DW            = 40;   // CORDIC vector component width
    localparam int AW            = 34;   // signed angle accumulator width
    localparam int PW            = 64;   // gain product width

    localparam logic signed [31:0] GAIN_Q30     = 32'sd1768195363;
    localparam logic signed [AW-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;

    localparam logic REG_PANO_WIDTH  = 1'b0;
    localparam logic REG_PANO_HEIGHT = 1'b1;

    typedef logic signed [DW-1:0] cval_t;
    typedef logic signed [AW-1:0] angle_t;

    typedef struct packed {
        cval_t  x;
        cval_t  y;
        angle_t a;
    } cordic_t;

    function automatic angle_t atan_entry(input int i);
        angle_t v;
        case (i)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            16:      v = 34'sd10430;
            17:      v = 34'sd5215;
            18:      v = 34'sd2608;
            19:      v = 34'sd1304;
            20:      v = 34'sd652;
            21:      v = 34'sd326;
            22:      v = 34'sd163;
            23:      v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // One vectoring iteration; i is a constant at every call site.
    function automatic cordic_t cordic_step(input cordic_t c, input int i);
        cordic_t r;
        cval_t   dx;
        cval_t   dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        if (!c.y[DW-1])
        begin
            r.x = c.x + dx;
            r.y = c.y - dy;
            r.a = c.a + atan_entry(i);
        end
        else
        begin
            r.x = c.x - dx;
            r.y = c.y + dy;
            r.a = c.a - atan_entry(i);
        end
        return r;
    endfunction

endpackage

@@ rtl/core/cubemap_to_equirect_address.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubemap_to_equirect_address
// Maps a cube face pixel to its equirectangular panorama column and row.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one face pixel per transfer (face, column, row).
//   Master stream m_*: one panorama address per transfer (column, row).
//   The configuration port sets panorama width and height; write it only
//   while no pixel is in flight.
// Pipeline: input transfer to output valid runs through 53
//   register stages (input, 25 azimuth, 25 polar, multiply, output).
// Throughput: one pixel per cycle unless stalled. Each of the two CORDIC
//   units is unrolled into 24 registered iterations, the azimuth unit feeding
//   its magnitude to the polar unit, so the whole path is one long pipeline.
// Reset: clears all valid bits and loads width 4096, height 2048.
// Stall: when the output register is full and m_tready is low, the whole
//   pipeline holds and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cubemap_to_equirect_address #(
    parameter int FACE_SIZE = cea_pkg::FACE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // face[2:0], face_col[14:3], face_row[26:15], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // pano_col[13:0], pano_row[27:14], zero
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_wdata
);
    import cea_pkg::*;

    localparam int NI = CORDIC_ITERS;
    localparam logic signed [15:0] N_S = 16'(FACE_SIZE);

    // Whole pipeline advances together; the output register decides.
    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    // Configuration
    logic [14:0] pano_width_reg;
    logic [14:0] pano_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pano_width_reg  <= 15'd4096;
            pano_height_reg <= 15'd2048;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PANO_WIDTH)
                pano_width_reg <= cfg_wdata;
            else if (cfg_index == REG_PANO_HEIGHT)
                pano_height_reg <= cfg_wdata;
        end
    end

    // Input register
    logic        in_vld_reg;
    logic [2:0]  face_reg;
    logic [11:0] col_reg;
    logic [11:0] row_reg;

    // Direction and azimuth pre-rotation
    cordic_t   dir_next;
    logic signed [31:0] z_next;
    logic      zero_next;
    logic      bad_next;
    logic signed [15:0] a_s;
    logic signed [15:0] b_s;
    logic signed [15:0] xd;
    logic signed [15:0] yd;
    logic signed [15:0] zd;
    cval_t     xs;
    cval_t     ys;

    always_comb
    begin
        a_s = $signed({3'b0, col_reg, 1'b1}) - N_S;
        b_s = $signed({3'b0, row_reg, 1'b1}) - N_S;
        bad_next = 1'b0;
        case (face_reg)
            3'd0:    begin xd = -a_s; yd = -N_S; zd = b_s;  end
            3'd1:    begin xd = a_s;  yd = N_S;  zd = b_s;  end
            3'd2:    begin xd = -b_s; yd = a_s;  zd = -N_S; end
            3'd3:    begin xd = b_s;  yd = a_s;  zd = N_S;  end
            3'd4:    begin xd = -N_S; yd = a_s;  zd = b_s;  end
            3'd5:    begin xd = N_S;  yd = -a_s; zd = b_s;  end
            default: begin xd = '0; yd = '0; zd = '0; bad_next = 1'b1; end
        endcase
        xs = {{(DW-32){xd[15]}}, xd, 16'b0};
        ys = {{(DW-32){yd[15]}}, yd, 16'b0};
        z_next    = {zd, 16'b0};
        zero_next = (xd == 16'sd0) && (yd == 16'sd0);
        // Negate a left-half vector and start at a half turn
        if (xd[15])
        begin
            dir_next.x = -xs;
            dir_next.y = -ys;
            dir_next.a = HALF_TURN;
        end
        else
        begin
            dir_next.x = xs;
            dir_next.y = ys;
            dir_next.a = '0;
        end
    end

    // Azimuth CORDIC chain, with z gain scaling running alongside
    cordic_t           ph_reg  [0:NI];
    cordic_t           ph_next [1:NI];
    logic              ph_vld_reg  [0:NI];
    logic              ph_zero_reg [0:NI];
    logic              ph_bad_reg  [0:NI];
    logic signed [PW-1:0] zs_reg [0:NI];
    logic signed [PW-1:0] zs_next [1:NI];

    always_comb
    begin
        for (int k = 1; k <= NI; k++)
        begin
            ph_next[k] = cordic_step(ph_reg[k-1], k - 1);
            if (k == 1)
                zs_next[k] = $signed(zs_reg[0][31:0]) * GAIN_Q30;   // gain product
            else if (k == 2)
                zs_next[k] = zs_reg[1] >>> 30;               // Zk, floor
            else
                zs_next[k] = zs_reg[k-1];
        end
    end

    // Polar pre-rotation
    cordic_t th_start;
    cval_t   zk;
    cval_t   mag;
    logic [31:0] phi_start;

    always_comb
    begin
        zk  = zs_reg[NI][DW-1:0];
        mag = ph_reg[NI].x;
        phi_start = ph_zero_reg[NI] ? 32'd0 : ph_reg[NI].a[31:0];
        if (zk[DW-1])
        begin
            th_start.x = mag;
            th_start.y = -zk;
            th_start.a = QUARTER_TURN;
        end
        else
        begin
            th_start.x = zk;
            th_start.y = mag;
            th_start.a = '0;
        end
    end

    // Polar CORDIC chain
    cordic_t     th_reg  [0:NI];
    cordic_t     th_next [1:NI];
    logic        th_vld_reg [0:NI];
    logic        th_bad_reg [0:NI];
    logic [31:0] phi_reg    [0:NI];

    always_comb
    begin
        for (int k = 1; k <= NI; k++)
            th_next[k] = cordic_step(th_reg[k-1], k - 1);
    end

    // Scaling
    logic        mul_vld_reg;
    logic        mul_bad_reg;
    logic [46:0] col_prod_reg;
    logic [47:0] row_prod_reg;
    logic [32:0] th_clamp;

    assign th_clamp = th_reg[NI].a[AW-1] ? 33'd0 : th_reg[NI].a[32:0];

    // Saturation
    logic [13:0] col_lim;
    logic [13:0] row_lim;
    logic [13:0] col_next;
    logic [13:0] row_next;
    logic [14:0] w_m1;
    logic [14:0] h_m1;
    logic [14:0] col_raw;
    logic [16:0] row_raw;
    logic [13:0] pano_col_reg;
    logic [13:0] pano_row_reg;

    always_comb
    begin
        w_m1    = pano_width_reg - 15'd1;
        h_m1    = pano_height_reg - 15'd1;
        col_lim = w_m1[14] ? 14'd16383 : w_m1[13:0];
        row_lim = h_m1[14] ? 14'd16383 : h_m1[13:0];
        col_raw = col_prod_reg[46:32];
        row_raw = row_prod_reg[47:31];
        if (pano_width_reg == 15'd0 || mul_bad_reg)
            col_next = '0;
        else if (col_raw > {1'b0, col_lim})
            col_next = col_lim;
        else
            col_next = col_raw[13:0];
        if (pano_height_reg == 15'd0 || mul_bad_reg)
            row_next = '0;
        else if (row_raw > {3'b0, row_lim})
            row_next = row_lim;
        else
            row_next = row_raw[13:0];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            mul_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= NI; k++)
            begin
                ph_vld_reg[k] <= 1'b0;
                th_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            in_vld_reg    <= s_tvalid;
            ph_vld_reg[0] <= in_vld_reg;
            for (int k = 1; k <= NI; k++)
            begin
                ph_vld_reg[k] <= ph_vld_reg[k-1];
                th_vld_reg[k] <= th_vld_reg[k-1];
            end
            th_vld_reg[0] <= ph_vld_reg[NI];
            mul_vld_reg   <= th_vld_reg[NI];
            out_valid_reg <= mul_vld_reg;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            face_reg <= s_tdata[2:0];
            col_reg  <= s_tdata[14:3];
            row_reg  <= s_tdata[26:15];

            ph_reg[0]      <= dir_next;
            zs_reg[0]      <= {{(PW-32){z_next[31]}}, z_next};
            ph_zero_reg[0] <= zero_next;
            ph_bad_reg[0]  <= bad_next;
            for (int k = 1; k <= NI; k++)
            begin
                ph_reg[k]      <= ph_next[k];
                zs_reg[k]      <= zs_next[k];
                ph_zero_reg[k] <= ph_zero_reg[k-1];
                ph_bad_reg[k]  <= ph_bad_reg[k-1];
            end

            th_reg[0]     <= th_start;
            phi_reg[0]    <= phi_start;
            th_bad_reg[0] <= ph_bad_reg[NI];
            for (int k = 1; k <= NI; k++)
            begin
                th_reg[k]     <= th_next[k];
                phi_reg[k]    <= phi_reg[k-1];
                th_bad_reg[k] <= th_bad_reg[k-1];
            end

            col_prod_reg <= phi_reg[NI] * pano_width_reg;
            row_prod_reg <= th_clamp * pano_height_reg;
            mul_bad_reg  <= th_bad_reg[NI];

            pano_col_reg <= col_next;
            pano_row_reg <= row_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, pano_row_reg, pano_col_reg};

endmodule
